@@ hdl/psm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int VOL_FRAC_W  = 15;
   localparam int OFFSET_W    = 24;
   localparam int POS_CFG_W   = 13;
   localparam int PITCH_W     = 24;
   localparam int VOLUME_W    = 16;
   localparam int DEST_IDX_W  = 30;
   localparam int MIX_LEN_W   = 29;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_MIX    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_OFFSET = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FROM_POS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_END  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME      = 3'd4;

   typedef struct packed {
      logic [1:0]                 command;
      logic signed [SAMPLE_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic                       in_window;
      logic                       last_of_mix;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]  dest_offset;
      logic [POS_CFG_W-1:0] from_position;
      logic [POS_CFG_W-1:0] window_end;
      logic [PITCH_W-1:0]   pitch;
      logic [VOLUME_W-1:0]  volume;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/psm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psm_front
   import psm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         q_valid,
   output req_type      q_word,
   input  wire logic    q_pop
);

   req_type   entry_ff [2];
   req_type   entry_in [2];
   logic      rd_ptr_ff, rd_ptr_in;
   logic      wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic      push;

   assign busy    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_word  = entry_ff[rd_ptr_ff];

   // unused command code is dropped here, never reaches the back end
   assign push = start && !busy && (req_data.command == CMD_CLEAR ||
      req_data.command == CMD_APPEND || req_data.command == CMD_MIX);

   always_comb begin
      entry_in  = entry_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = req_data;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_pop && q_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !(q_pop && q_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop && q_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/psm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psm_back
   import psm_pkg::*;
#(
   parameter int SOURCE_DEPTH = 4096
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_valid,
   input  wire req_type q_word,
   output logic         q_pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW    = $clog2(SOURCE_DEPTH);
   localparam int CW    = AW + 1;
   localparam int POSW  = CW + FRAC_W;
   localparam int SUMW  = ((POSW > PITCH_W) ? POSW : PITCH_W) + 1;
   localparam int EW    = (CW > POS_CFG_W) ? CW : POS_CFG_W;
   localparam int NW    = EW + FRAC_W + 2;
   localparam int DW    = PITCH_W + 1;
   localparam int KW    = $clog2(NW + 1);
   localparam int PRODW = SAMPLE_W + FRAC_W + 2;
   localparam int VPW   = SAMPLE_W + VOLUME_W + 1;
   localparam int MSUMW = SAMPLE_W + VOLUME_W + 3;
   localparam int RESW  = MSUMW - VOL_FRAC_W - 1;

   localparam logic [POSW-1:0]      POS_CAP  = POSW'(SOURCE_DEPTH) << FRAC_W;
   localparam logic [MIX_LEN_W-1:0] LEN_MAX  = '1;
   localparam logic [DEST_IDX_W-1:0] IDX_MAX = '1;
   localparam logic [PITCH_W-1:0]   PITCH_ONE = PITCH_W'(1) << FRAC_W;
   localparam logic signed [RESW-1:0] SAT_HI = RESW'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [RESW-1:0] SAT_LO = -RESW'(1 << (SAMPLE_W - 1));

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIV    = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_INTERP = 3'd4;
   localparam logic [2:0] S_SCALE  = 3'd5;
   localparam logic [2:0] S_MIX    = 3'd6;

   logic signed [SAMPLE_W-1:0] mem [SOURCE_DEPTH];

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          loaded_ff, loaded_in;
   logic [DEST_IDX_W-1:0]  dest_idx_ff, dest_idx_in;
   logic [POSW-1:0]        pos_ff, pos_in;
   logic [MIX_LEN_W-1:0]   len_ff, len_in;
   logic                   len_valid_ff, len_valid_in;
   logic signed [SAMPLE_W-1:0] dest_ff, dest_in;
   logic [NW-1:0]          num_ff, num_in;
   logic [NW-1:0]          quo_ff, quo_in;
   logic [DW:0]            rem_ff, rem_in;
   logic [KW-1:0]          step_ff, step_in;
   logic                   zero_ff, zero_in;
   logic                   use_next_ff, use_next_in;
   logic                   last_ff, last_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic signed [SAMPLE_W-1:0] prev_ff, next_ff;
   logic signed [PRODW-1:0] prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] interp_ff, interp_in;
   logic signed [VPW-1:0]  vprod_ff, vprod_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   mem_we;
   logic [AW-1:0]          rd_addr0, rd_addr1;
   logic [PITCH_W-1:0]     step_pitch;
   logic [EW-1:0]          end_pos, from_ext, span;
   logic [DW:0]            rem_sh;
   logic [DW-1:0]          divisor;
   logic [CW-1:0]          pos_idx;
   logic [DEST_IDX_W-1:0]  mix_i;
   logic                   in_win;
   logic signed [SAMPLE_W:0] diff;
   logic signed [PRODW-1:0] interp_num;
   logic signed [PRODW-1:0] interp_adj;
   logic signed [MSUMW-1:0] mix_sum, mix_adj;
   logic signed [RESW-1:0]  mix_res;
   logic [SUMW-1:0]        pos_sum;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign step_pitch = (cfg.pitch == '0) ? PITCH_ONE : cfg.pitch;
   assign divisor    = {step_pitch, 1'b0};
   assign end_pos    = (cfg.window_end == '0) ? EW'(loaded_ff) : EW'(cfg.window_end);
   assign from_ext   = EW'(cfg.from_position);
   assign span       = (end_pos > from_ext) ? (end_pos - from_ext) : '0;
   assign rem_sh     = {rem_ff[DW-1:0], num_ff[NW-1]};
   assign pos_idx    = pos_ff[POSW-1:FRAC_W];
   assign rd_addr0   = pos_idx[AW-1:0];
   assign rd_addr1   = AW'(pos_idx + CW'(1));
   assign mix_i      = dest_idx_ff - DEST_IDX_W'(cfg.dest_offset);
   assign in_win     = (dest_idx_ff >= DEST_IDX_W'(cfg.dest_offset)) &&
                       (mix_i < DEST_IDX_W'(len_ff));
   // next sample past the loaded length reads as zero
   assign diff       = (use_next_ff ? (SAMPLE_W+1)'(next_ff) : (SAMPLE_W+1)'(0))
                       - (SAMPLE_W+1)'(prev_ff);
   assign interp_num = (PRODW'(prev_ff) <<< FRAC_W) + prod_ff;
   // truncate toward zero: bias negatives before the arithmetic shift
   assign interp_adj = interp_num + (interp_num[PRODW-1] ?
                       PRODW'((1 << FRAC_W) - 1) : PRODW'(0));
   assign mix_sum    = (MSUMW'(dest_ff) <<< VOL_FRAC_W) + MSUMW'(vprod_ff);
   assign mix_adj    = mix_sum + (mix_sum[MSUMW-1] ?
                       MSUMW'((1 << (VOL_FRAC_W + 1)) - 1) : MSUMW'(0));
   assign mix_res    = RESW'(mix_adj >>> (VOL_FRAC_W + 1));
   assign pos_sum    = SUMW'(pos_ff) + SUMW'(step_pitch);

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      dest_idx_in   = dest_idx_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      len_valid_in  = len_valid_ff;
      dest_in       = dest_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      zero_in       = zero_ff;
      use_next_in   = use_next_ff;
      last_in       = last_ff;
      frac_in       = frac_ff;
      prod_in       = prod_ff;
      interp_in     = interp_ff;
      vprod_in      = vprod_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               dest_in = q_word.sample_value;
               unique case (q_word.command)
                  CMD_CLEAR: begin
                     loaded_in    = '0;
                     dest_idx_in  = '0;
                     pos_in       = '0;
                     len_in       = '0;
                     len_valid_in = 1'b0;
                  end
                  CMD_APPEND: begin
                     if (loaded_ff < CW'(SOURCE_DEPTH)) begin
                        mem_we    = 1'b1;
                        loaded_in = loaded_ff + CW'(1);
                     end
                  end
                  default: begin
                     if (len_valid_ff) begin
                        state_in = S_CHECK;
                     end else begin
                        // length = (span*2^17 + p) / (2p), one quotient bit a cycle
                        num_in   = (NW'(span) << (FRAC_W + 1)) + NW'(step_pitch);
                        quo_in   = '0;
                        rem_in   = '0;
                        step_in  = KW'(NW);
                        state_in = S_DIV;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            num_in = num_ff << 1;
            if (rem_sh >= (DW+1)'(divisor)) begin
               rem_in = rem_sh - (DW+1)'(divisor);
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            step_in = step_ff - KW'(1);
            if (step_ff == KW'(1)) begin
               len_in = (quo_in > NW'(LEN_MAX)) ? LEN_MAX : MIX_LEN_W'(quo_in);
               len_valid_in = 1'b1;
               pos_in = (EW'(cfg.from_position) > EW'(SOURCE_DEPTH)) ? POS_CAP
                        : (POSW'(cfg.from_position) << FRAC_W);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (in_win) begin
               zero_in     = (pos_idx >= loaded_ff);
               use_next_in = (pos_ff[FRAC_W-1:0] != '0) &&
                             ((CW+1)'(pos_idx) + (CW+1)'(1) < (CW+1)'(loaded_ff));
               frac_in     = pos_ff[FRAC_W-1:0];
               last_in     = (mix_i + DEST_IDX_W'(1) == DEST_IDX_W'(len_ff));
               state_in    = S_READ;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_data_in.mixed_sample = dest_ff;
               rsp_data_in.in_window    = 1'b0;
               rsp_data_in.last_of_mix  = 1'b0;
               if (dest_idx_ff != IDX_MAX) begin
                  dest_idx_in = dest_idx_ff + DEST_IDX_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            prod_in  = PRODW'(diff * $signed({1'b0, frac_ff}));
            state_in = S_INTERP;
         end
         S_INTERP: begin
            interp_in = zero_ff ? '0 : SAMPLE_W'(interp_adj >>> FRAC_W);
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            vprod_in = interp_ff * $signed({1'b0, cfg.volume});
            state_in = S_MIX;
         end
         S_MIX: begin
            rsp_strobe_in = 1'b1;
            if (mix_res > SAT_HI) begin
               rsp_data_in.mixed_sample = SAMPLE_W'(SAT_HI);
            end else if (mix_res < SAT_LO) begin
               rsp_data_in.mixed_sample = SAMPLE_W'(SAT_LO);
            end else begin
               rsp_data_in.mixed_sample = SAMPLE_W'(mix_res);
            end
            rsp_data_in.in_window   = 1'b1;
            rsp_data_in.last_of_mix = last_ff;
            pos_in = (pos_sum > SUMW'(POS_CAP)) ? POS_CAP : POSW'(pos_sum);
            if (dest_idx_ff != IDX_MAX) begin
               dest_idx_in = dest_idx_ff + DEST_IDX_W'(1);
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[loaded_ff[AW-1:0]] <= q_word.sample_value;
      end
      if (state_ff == S_CHECK) begin
         prev_ff <= mem[rd_addr0];
         next_ff <= mem[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      zero_ff     <= zero_in;
      use_next_ff <= use_next_in;
      last_ff     <= last_in;
      frac_ff     <= frac_in;
      prod_ff     <= prod_in;
      interp_ff   <= interp_in;
      vprod_ff    <= vprod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         loaded_ff     <= '0;
         dest_idx_ff   <= '0;
         pos_ff        <= '0;
         len_ff        <= '0;
         len_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         dest_idx_ff   <= dest_idx_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         len_valid_ff  <= len_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/pitched_sample_mixer_core.sv @@
// Mixes a stored source clip into a destination sample stream with pitch and
// volume. A word taken on start is registered in a two-word queue, where it
// waits until the back end is idle and pops it. The back end handles a clear or
// append word in its pop state; a mix word outside the window is popped, checked
// and passed through, and one inside it goes through pop, check and memory read,
// fraction multiply, interpolate, volume multiply and saturate. The result strobe
// is registered after the last step. The first mix word after reset or clear also
// passes through the bit-serial window length divider. busy is high only while the
// queue is full. Each result appears on rsp_data for one cycle with rsp_strobe
// and cannot be stalled. The csr port is always ready and must only be written
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pitched_sample_mixer_core
   import psm_pkg::*;
#(
   parameter int SOURCE_DEPTH = 4096
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_valid;
   req_type q_word;
   logic    q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEST_OFFSET: cfg_in.dest_offset   = csr_data[OFFSET_W-1:0];
            CSR_FROM_POS:    cfg_in.from_position = csr_data[POS_CFG_W-1:0];
            CSR_WINDOW_END:  cfg_in.window_end    = csr_data[POS_CFG_W-1:0];
            CSR_PITCH:       cfg_in.pitch         = csr_data[PITCH_W-1:0];
            CSR_VOLUME:      cfg_in.volume        = csr_data[VOLUME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_offset   <= '0;
         cfg_ff.from_position <= '0;
         cfg_ff.window_end    <= '0;
         cfg_ff.pitch         <= PITCH_W'(1) << FRAC_W;
         cfg_ff.volume        <= VOLUME_W'(1) << VOL_FRAC_W;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   psm_back #(
      .SOURCE_DEPTH (SOURCE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
